// File: src/u8v_pkg.sv
// Package with the shared types, constants and code point checks of the UTF-8 string validator.
`timescale 1ns / 1ps

package u8v_pkg;

  localparam int unsigned MaxStringBytes = 65536;
  localparam int unsigned CountW         = 17;
  localparam int unsigned AccW           = 21;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxStringBytes);

  // Sequence lengths as held in the state.
  localparam logic [2:0] SeqLen1 = 3'd1;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // Lead byte limits.
  localparam logic [7:0] LeadOverlongA = 8'hC0;
  localparam logic [7:0] LeadOverlongB = 8'hC1;
  localparam logic [7:0] LeadMax       = 8'hF4;
  localparam logic [7:0] AsciiMax      = 8'h7F;

  typedef struct packed {
    logic              error_seen;
    logic [1:0]        pending_continuations;
    logic [AccW-1:0]   code_point_accumulator;
    logic [2:0]        sequence_length;
    logic [CountW-1:0] byte_count;
  } u8v_state_t;

  typedef struct packed {
    logic has_result;
    logic string_valid;
  } u8v_result_t;

  // True when a completed code point breaks one of the rules.
  function automatic logic point_is_bad(logic [AccW-1:0] cp, logic [2:0] len);
    logic bad;
    bad = 1'b0;
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) bad = 1'b1;
    if (len == SeqLen3 && cp < 21'h000800) bad = 1'b1;
    if (len == SeqLen4 && (cp < 21'h010000 || cp > 21'h10FFFF)) bad = 1'b1;
    if (cp >= 21'h00FDD0 && cp <= 21'h00FDEF) bad = 1'b1;
    if (cp[15:0] == 16'hFFFE || cp[15:0] == 16'hFFFF) bad = 1'b1;
    if (cp <= 21'h00001F || (cp >= 21'h00007F && cp <= 21'h00009F)) bad = 1'b1;
    return bad;
  endfunction

endpackage

// File: src/u8v_in_if.sv
// Input channel interface: one string byte per transfer with its end and empty marks.
`timescale 1ns / 1ps

interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_string;

  modport source (output valid, output data_byte, output last_byte, output empty_string,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input empty_string,
                output ready);
endinterface

// File: src/u8v_out_if.sv
// Output channel interface: one verdict per string.
`timescale 1ns / 1ps

interface u8v_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink (input valid, input string_valid, output ready);
endinterface

// File: src/u8v_decode.sv
// Next-state logic: decodes one byte against the string state and forms the verdict.
`timescale 1ns / 1ps

module u8v_decode (
  input  u8v_pkg::u8v_state_t  state,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 empty_string,
  output u8v_pkg::u8v_state_t  state_next,
  output u8v_pkg::u8v_result_t result
);

  u8v_pkg::u8v_state_t upd;
  logic [u8v_pkg::AccW-1:0] acc_shift;

  assign acc_shift = {state.code_point_accumulator[u8v_pkg::AccW-7:0], data_byte[5:0]};

  always_comb begin
    upd = state;
    if (state.byte_count >= u8v_pkg::MaxCount) begin
      upd.error_seen = 1'b1;
    end else begin
      upd.byte_count = state.byte_count + u8v_pkg::CountW'(1);
    end

    // Once an error is seen the remaining bytes are only counted.
    if (!upd.error_seen) begin
      if (state.pending_continuations == 2'd0) begin
        if (data_byte == 8'h00) begin
          upd.error_seen = 1'b1;
        end else if (data_byte <= u8v_pkg::AsciiMax) begin
          upd.sequence_length        = u8v_pkg::SeqLen1;
          upd.code_point_accumulator = u8v_pkg::AccW'(data_byte);
          if (u8v_pkg::point_is_bad(u8v_pkg::AccW'(data_byte), u8v_pkg::SeqLen1)) begin
            upd.error_seen = 1'b1;
          end
        end else if (data_byte[7:5] == 3'b110) begin
          if (data_byte == u8v_pkg::LeadOverlongA || data_byte == u8v_pkg::LeadOverlongB) begin
            upd.error_seen = 1'b1;
          end else begin
            upd.sequence_length        = u8v_pkg::SeqLen2;
            upd.code_point_accumulator = u8v_pkg::AccW'(data_byte[4:0]);
            upd.pending_continuations  = 2'd1;
          end
        end else if (data_byte[7:4] == 4'b1110) begin
          upd.sequence_length        = u8v_pkg::SeqLen3;
          upd.code_point_accumulator = u8v_pkg::AccW'(data_byte[3:0]);
          upd.pending_continuations  = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          if (data_byte > u8v_pkg::LeadMax) begin
            upd.error_seen = 1'b1;
          end else begin
            upd.sequence_length        = u8v_pkg::SeqLen4;
            upd.code_point_accumulator = u8v_pkg::AccW'(data_byte[2:0]);
            upd.pending_continuations  = 2'd3;
          end
        end else begin
          upd.error_seen = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        upd.error_seen = 1'b1;
      end else begin
        upd.code_point_accumulator = acc_shift;
        upd.pending_continuations  = state.pending_continuations - 2'd1;
        if (state.pending_continuations == 2'd1 &&
            u8v_pkg::point_is_bad(acc_shift, state.sequence_length)) begin
          upd.error_seen = 1'b1;
        end
      end
    end
  end

  // Every verdict returns the state to its cleared form for the next string.
  always_comb begin
    state_next          = upd;
    result.has_result   = 1'b0;
    result.string_valid = 1'b0;
    if (empty_string) begin
      state_next        = '0;
      result.has_result = 1'b1;
    end else if (last_byte) begin
      state_next          = '0;
      result.has_result   = 1'b1;
      result.string_valid = !upd.error_seen && (upd.pending_continuations == 2'd0);
    end
  end

endmodule

// File: src/utf8_string_validator_top.sv
// Top level of the UTF-8 string validator: input register, string state and result register.
//
// Strings arrive on the in channel one byte per transfer; last_byte marks the final
// byte and empty_string stands for a zero-length string, whose byte is ignored and
// which also drops any partial string. For each string exactly one transfer leaves
// on the out channel, at the final byte or the empty mark: string_valid is 1 when the
// string is well-formed UTF-8 with no zero byte, surrogate, overlong or out-of-range
// encoding, noncharacter or control character, and at most 65536 bytes long.
// Bytes that do not end a string give no output transfer.
// A byte taken into the input register is decoded from there, and its verdict is
// registered in the result register, from which it is shown on out.
// Throughput: one byte per cycle while no verdict waits on a full result register,
// set by the single decode step between the input register and the result register.
// If out is stalled, the result register holds its verdict; further bytes are still
// decoded until a second verdict would be needed, and then in.ready falls.
// A synchronous reset empties both registers and clears the string state.
`timescale 1ns / 1ps

module utf8_string_validator_top (
  input logic       clk,
  input logic       rst,
  u8v_in_if.sink    in,
  u8v_out_if.source out
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_empty;

  u8v_pkg::u8v_state_t  state;
  u8v_pkg::u8v_state_t  state_next;
  u8v_pkg::u8v_result_t result;

  logic out_valid;
  logic out_data;
  logic out_free;
  logic advance;

  u8v_decode decode (
    .state        (state),
    .data_byte    (in_byte),
    .last_byte    (in_last),
    .empty_string (in_empty),
    .state_next   (state_next),
    .result       (result)
  );

  assign out_free = !out_valid || out.ready;
  // A byte leaves the input register unless its verdict has nowhere to go.
  assign advance  = in_valid && (!result.has_result || out_free);
  assign in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in.ready) begin
      in_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      in_byte  <= in.data_byte;
      in_last  <= in.last_byte;
      in_empty <= in.empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.has_result) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.has_result) begin
      out_data <= result.string_valid;
    end
  end

  assign out.valid        = out_valid;
  assign out.string_valid = out_data;

endmodule

// File: dv/tb_utf8_string_validator_top.sv
// Self-checking testbench for the UTF-8 string validator top level.
`timescale 1ns / 1ps

module tb_utf8_string_validator_top;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomPerPhase = 470;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_string;
  } byte_item_t;

  typedef struct packed {
    logic        failed;
    logic [1:0]  cont_left;
    logic [20:0] code_point;
    logic [2:0]  seq_len;
    logic [16:0] bytes_seen;
  } decode_state_t;

  logic clk;
  logic rst;

  u8v_in_if  byte_ch ();
  u8v_out_if verdict_ch ();

  utf8_string_validator_top dut (
    .clk (clk),
    .rst (rst),
    .in  (byte_ch),
    .out (verdict_ch)
  );

  byte_item_t           pending_bytes[$];
  logic                 expected_verdicts[$];
  decode_state_t        decoder;
  byte_item_t           drive_item;
  byte_item_t           seen_item;
  u8v_pkg::u8v_result_t predicted;
  logic                 wanted;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned strings_checked;
  int unsigned strings_passed;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic code_point_rejected(logic [20:0] cp, logic [2:0] len);
    return (cp >= 21'h00D800 && cp <= 21'h00DFFF) ||
           (len == u8v_pkg::SeqLen3 && cp < 21'h000800) ||
           (len == u8v_pkg::SeqLen4 && (cp < 21'h010000 || cp > 21'h10FFFF)) ||
           (cp >= 21'h00FDD0 && cp <= 21'h00FDEF) ||
           (cp[15:0] >= 16'hFFFE) ||
           (cp <= 21'h00001F) || (cp >= 21'h00007F && cp <= 21'h00009F);
  endfunction

  // Advances the decoder by one byte and returns the verdict it yields, if any.
  function automatic u8v_pkg::u8v_result_t predict_verdict(byte_item_t it);
    u8v_pkg::u8v_result_t r;
    logic [7:0]           b;
    r = '0;
    b = it.data_byte;
    if (it.empty_string) begin
      decoder = '0;
      r.has_result = 1'b1;
      return r;
    end
    if (decoder.bytes_seen >= 17'(u8v_pkg::MaxStringBytes)) begin
      decoder.failed = 1'b1;
    end else begin
      decoder.bytes_seen = decoder.bytes_seen + 17'd1;
    end
    // Once the string has failed, bytes are only counted.
    if (!decoder.failed) begin
      if (decoder.cont_left == 2'd0) begin
        if (b == 8'h00) begin
          decoder.failed = 1'b1;
        end else if (b <= u8v_pkg::AsciiMax) begin
          decoder.seq_len    = u8v_pkg::SeqLen1;
          decoder.code_point = {13'd0, b};
          if (code_point_rejected(decoder.code_point, u8v_pkg::SeqLen1)) decoder.failed = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          if (b == u8v_pkg::LeadOverlongA || b == u8v_pkg::LeadOverlongB) begin
            decoder.failed = 1'b1;
          end else begin
            decoder.seq_len    = u8v_pkg::SeqLen2;
            decoder.code_point = {16'd0, b[4:0]};
            decoder.cont_left  = 2'd1;
          end
        end else if (b[7:4] == 4'b1110) begin
          decoder.seq_len    = u8v_pkg::SeqLen3;
          decoder.code_point = {17'd0, b[3:0]};
          decoder.cont_left  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          if (b > u8v_pkg::LeadMax) begin
            decoder.failed = 1'b1;
          end else begin
            decoder.seq_len    = u8v_pkg::SeqLen4;
            decoder.code_point = {18'd0, b[2:0]};
            decoder.cont_left  = 2'd3;
          end
        end else begin
          decoder.failed = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        decoder.failed = 1'b1;
      end else begin
        decoder.code_point = {decoder.code_point[14:0], b[5:0]};
        decoder.cont_left  = decoder.cont_left - 2'd1;
        if (decoder.cont_left == 2'd0 &&
            code_point_rejected(decoder.code_point, decoder.seq_len)) begin
          decoder.failed = 1'b1;
        end
      end
    end
    if (it.last_byte) begin
      r.has_result   = 1'b1;
      r.string_valid = !decoder.failed && decoder.cont_left == 2'd0;
      decoder = '0;
    end
    return r;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last, input logic empty);
    pending_bytes.push_back('{data_byte: b, last_byte: last, empty_string: empty});
    bytes_queued++;
  endtask

  task automatic queue_string(input logic [7:0] s[$]);
    foreach (s[i]) queue_byte(s[i], i == s.size() - 1, 1'b0);
  endtask

  task automatic append_point(input logic [20:0] cp, input int nbytes, ref logic [7:0] s[$]);
    case (nbytes)
      1: s.push_back(cp[7:0]);
      2: begin
        s.push_back({3'b110, cp[10:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      3: begin
        s.push_back({4'b1110, cp[15:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      default: begin
        s.push_back({5'b11110, cp[20:18]});
        s.push_back({2'b10, cp[17:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Mostly legal code points, with a share close to each rule's boundary.
  task automatic append_random_point(ref logic [7:0] s[$]);
    int unsigned pick;
    logic [20:0] cp;
    pick = $urandom_range(0, 19);
    if (pick <= 5) begin
      append_point(21'($urandom_range(8'h20, 8'h7E)), 1, s);
    end else if (pick == 6) begin
      append_point(21'($urandom_range(8'h01, 8'h7F)), 1, s);
    end else if (pick <= 8) begin
      append_point(21'($urandom_range(12'h080, 12'h7FF)), 2, s);
    end else if (pick <= 11) begin
      append_point(21'($urandom_range(16'h0800, 16'hFFFF)), 3, s);
    end else if (pick == 12) begin
      case ($urandom_range(0, 3))
        0: cp = 21'($urandom_range(16'hD7F0, 16'hE00F));
        1: cp = 21'($urandom_range(16'hFDC0, 16'hFDFF));
        2: cp = 21'($urandom_range(16'hFFF0, 16'hFFFF));
        default: cp = 21'($urandom_range(16'h07F0, 16'h080F));
      endcase
      append_point(cp, 3, s);
    end else if (pick <= 15) begin
      append_point(21'($urandom_range(21'h010000, 21'h10FFFF)), 4, s);
    end else if (pick == 16) begin
      case ($urandom_range(0, 2))
        0: cp = {5'($urandom_range(1, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
        1: cp = 21'($urandom_range(21'h10FFF0, 21'h11000F));
        default: cp = 21'($urandom_range(21'h00FFF0, 21'h01000F));
      endcase
      append_point(cp, 4, s);
    end else if (pick == 17) begin
      // Two-byte forms of ASCII and of the upper control range.
      append_point(21'($urandom_range(8'h00, 8'h9F)), 2, s);
    end else if (pick == 18) begin
      append_point(21'($urandom_range(21'h000000, 21'h1FFFFF)), 4, s);
    end else begin
      append_point(21'($urandom_range(12'h000, 12'h7FF)), 3, s);
    end
  endtask

  task automatic queue_random_string();
    logic [7:0]  s[$];
    int unsigned kind;
    int unsigned pos;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind >= 96) begin
      queue_byte(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    if (kind < 88) begin
      repeat ($urandom_range(1, 10)) append_random_point(s);
    end else begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
    end
    if (kind >= 60 && kind < 80) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0: s[pos] = 8'($urandom);
        1: if (s.size() > 1) void'(s.pop_back());
        default: s.insert(pos, 8'($urandom));
      endcase
    end
    if (kind >= 80 && kind < 88) begin
      // A partial string dropped by an empty mark.
      cut = $urandom_range(1, s.size());
      for (int i = 0; i < cut; i++) queue_byte(s[i], 1'b0, 1'b0);
      queue_byte(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      queue_string(s);
    end
  endtask

  task automatic queue_random_phase();
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < RandomPerPhase) queue_random_string();
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (bytes_accepted != bytes_queued || expected_verdicts.size() != 0);
  endtask

  // Sender: once the previous byte has been taken, a new one is offered unless the idle draw holds it back.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drive_item = pending_bytes.pop_front();
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= drive_item.data_byte;
        byte_ch.last_byte    <= drive_item.last_byte;
        byte_ch.empty_string <= drive_item.empty_string;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      verdict_ch.ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  // Checks each verdict transfer, then predicts from each byte transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        strings_checked++;
        if (verdict_ch.string_valid) strings_passed++;
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t: verdict with none expected, expected none, actual %0b",
                   $time, verdict_ch.string_valid);
        end else begin
          wanted = expected_verdicts.pop_front();
          if (wanted !== verdict_ch.string_valid) begin
            fail_count++;
            $display("%0t: string_valid mismatch, expected %0b, actual %0b",
                     $time, wanted, verdict_ch.string_valid);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_accepted++;
        seen_item = '{data_byte: byte_ch.data_byte, last_byte: byte_ch.last_byte,
                      empty_string: byte_ch.empty_string};
        predicted = predict_verdict(seen_item);
        if (predicted.has_result) expected_verdicts.push_back(predicted.string_valid);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles, run abandoned", $time, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst                     = 1'b1;
    decoder                 = '0;
    tx_idle_pct             = 20;
    rx_idle_pct             = 58;
    bytes_queued            = 0;
    bytes_accepted          = 0;
    strings_checked         = 0;
    strings_passed          = 0;
    fail_count              = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_string({8'h41});
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_string({8'h00});
    queue_string({8'h7F});
    queue_string({8'hC0, 8'h80});
    queue_string({8'hFF});
    queue_string({8'h80, 8'h41});
    queue_string({8'hC2, 8'hA0});
    queue_string({8'hE0, 8'hA0});
    queue_string({8'hED, 8'hA0, 8'h80});
    queue_string({8'hE0, 8'h9F, 8'hBF});
    queue_string({8'hEF, 8'hB7, 8'h90});
    queue_string({8'hF4, 8'h8F, 8'hBF, 8'hBD});
    // An empty mark without a last byte still ends the partial string.
    queue_byte(8'h41, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_random_phase();
    wait_until_drained();

    tx_idle_pct = 58;
    rx_idle_pct = 20;
    queue_random_phase();
    wait_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_phase();
    wait_until_drained();
    repeat (DrainCycles) @(negedge clk);

    if (expected_verdicts.size() != 0) begin
      fail_count++;
      $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
    end
    $display("Checked %0d strings (%0d valid) from %0d bytes under three flow-control mixes.",
             strings_checked, strings_passed, bytes_accepted);
    $display("Covered corner strings, random, corrupted and noise strings and empty marks.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: utf8_string_validator_top.f
src/u8v_pkg.sv
src/u8v_in_if.sv
src/u8v_out_if.sv
src/u8v_decode.sv
src/utf8_string_validator_top.sv
dv/tb_utf8_string_validator_top.sv
